// ===== hdl/aprsc_pkg.sv =====
// Shared types, constants and the soft-clip table for the allpass reverb.
`timescale 1ns / 1ps

package aprsc_pkg;

    localparam int DEF_LONG_DELAY_SAMPLES  = 1309;
    localparam int DEF_SHORT_DELAY_SAMPLES = 313;
    localparam int DEF_DELAY_WORD_BITS     = 20;

    localparam int SAMPLE_BITS = 18;
    localparam int PCM_BITS    = 16;
    localparam int WET_BITS    = 16;
    localparam int GAIN_BITS   = 15;
    localparam int CFG_DATA_BITS = 16;
    localparam int Q15_BITS    = 15;

    localparam logic [WET_BITS-1:0]  WET_RESET  = 16'd5898;
    localparam logic [WET_BITS-1:0]  WET_ONE    = 16'd32768;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 15'd22938;

    localparam int CLIP_STEP_BITS = 13;
    localparam int CLIP_SEG_BITS  = 4;
    localparam int CLIP_VAL_BITS  = 15;
    localparam int CLIP_SEGMENTS  = 16;

    typedef enum logic [0:0] {
        CFG_WET_MIX      = 1'b0,
        CFG_ALLPASS_GAIN = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_L_GD,
        ST_L_WR,
        ST_L_GW,
        ST_L_OUT,
        ST_S_GD,
        ST_S_WR,
        ST_S_GW,
        ST_S_OUT,
        ST_M_WET,
        ST_M_SUM,
        ST_C_MUL,
        ST_C_FIN
    } state_t;

    // tanh(1.2x)/1.2 * 32767 at steps of 0.25 over [0,4]
    function automatic logic [CLIP_VAL_BITS-1:0] clip_point(input logic [CLIP_SEG_BITS:0] idx);
        logic [CLIP_VAL_BITS-1:0] v;
        case (idx)
            5'd0:    v = 15'd0;
            5'd1:    v = 15'd7955;
            5'd2:    v = 15'd14665;
            5'd3:    v = 15'd19559;
            5'd4:    v = 15'd22764;
            5'd5:    v = 15'd24716;
            5'd6:    v = 15'd25853;
            5'd7:    v = 15'd26499;
            5'd8:    v = 15'd26860;
            5'd9:    v = 15'd27060;
            5'd10:   v = 15'd27171;
            5'd11:   v = 15'd27232;
            5'd12:   v = 15'd27265;
            5'd13:   v = 15'd27283;
            5'd14:   v = 15'd27294;
            5'd15:   v = 15'd27299;
            default: v = 15'd27302;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/aprsc_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module aprsc_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/allpass_reverb_soft_clip.sv =====
// pcm_out is registered; a new sample beat is accepted only when idle, after the last
// result has entered the output register (held while out_valid waits on out_ready).
// One shared multiplier with a registered product carries each stage's two gain
// products, the two mix products and the interpolation product, in strict order.
// Reset: gain and wet mix return to their defaults, both delay positions go to
// zero and both delay lines read as empty; the delay memories are not cleared.
`timescale 1ns / 1ps

module allpass_reverb_soft_clip #(
    parameter int LONG_DELAY_SAMPLES  = aprsc_pkg::DEF_LONG_DELAY_SAMPLES,
    parameter int SHORT_DELAY_SAMPLES = aprsc_pkg::DEF_SHORT_DELAY_SAMPLES,
    parameter int DELAY_WORD_BITS     = aprsc_pkg::DEF_DELAY_WORD_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  aprsc_pkg::cfg_reg_t                    cfg_index,
    input  logic [aprsc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [aprsc_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                   new_sound,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [aprsc_pkg::PCM_BITS-1:0]  pcm_out
);

    import aprsc_pkg::*;

    localparam int W   = DELAY_WORD_BITS;
    localparam int MA  = (W > SAMPLE_BITS) ? W : SAMPLE_BITS;
    localparam int MB  = SAMPLE_BITS;
    localparam int PW  = MA + MB;
    localparam int VW  = PW + 1;
    localparam int LAW = $clog2(LONG_DELAY_SAMPLES);
    localparam int SAW = $clog2(SHORT_DELAY_SAMPLES);

    localparam logic signed [VW-1:0] WORD_MAX   = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [VW-1:0] WORD_MIN   = ~WORD_MAX;
    localparam logic signed [VW-1:0] ROUND_HALF = {{(VW-Q15_BITS){1'b0}}, 1'b1,
                                                   {(Q15_BITS-1){1'b0}}};
    localparam logic [VW-1:0] CLIP_LIMIT = {{(VW-CLIP_STEP_BITS-CLIP_SEG_BITS-1){1'b0}},
                                            1'b1, {(CLIP_STEP_BITS+CLIP_SEG_BITS){1'b0}}};
    localparam logic [LAW-1:0] LONG_LAST  = LAW'(LONG_DELAY_SAMPLES - 1);
    localparam logic [SAW-1:0] SHORT_LAST = SAW'(SHORT_DELAY_SAMPLES - 1);

    function automatic logic signed [W-1:0] sat_word(input logic signed [VW-1:0] v);
        logic signed [W-1:0] r;
        if (v > WORD_MAX)
            r = WORD_MAX[W-1:0];
        else if (v < WORD_MIN)
            r = WORD_MIN[W-1:0];
        else
            r = v[W-1:0];
        return r;
    endfunction

    // floor((v + 2^14) / 2^15)
    function automatic logic signed [VW-1:0] rnd_q15(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] t;
        t = v + ROUND_HALF;
        return t >>> Q15_BITS;
    endfunction

    state_t state_reg, state_next;

    logic [WET_BITS-1:0]  wet_reg;
    logic [GAIN_BITS-1:0] gain_reg;

    logic [LAW-1:0] long_pos_reg, long_pos_next;
    logic [SAW-1:0] short_pos_reg, short_pos_next;
    logic           long_filled_reg, long_filled_next;
    logic           short_filled_reg, short_filled_next;
    logic           out_valid_reg, out_valid_next;

    logic signed [SAMPLE_BITS-1:0] s_reg, s_next;
    logic signed [MA-1:0]          x_reg, x_next;
    logic signed [W-1:0]           d_reg, d_next;
    logic signed [W-1:0]           w_reg, w_next;
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic signed [PW-1:0]          acc_reg, acc_next;
    logic signed [W-1:0]           mix_reg, mix_next;
    logic [CLIP_VAL_BITS-1:0]      clip_lo_reg, clip_lo_next;
    logic                          clip_neg_reg, clip_neg_next;
    logic                          clip_last_reg, clip_last_next;
    logic signed [PCM_BITS-1:0]    pcm_reg, pcm_next;

    logic                 long_we, long_re;
    logic [LAW-1:0]       long_raddr;
    logic [W-1:0]         long_rdata;
    logic                 short_we, short_re;
    logic [W-1:0]         short_rdata;
    logic [W-1:0]         ram_wdata;

    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic [WET_BITS-1:0]  wet_eff;
    logic [WET_BITS-1:0]  dry;
    logic signed [W-1:0]  d_sel;
    logic signed [W-1:0]  w_val;
    logic signed [W-1:0]  y_val;
    logic [W-1:0]         mag;
    logic [VW-1:0]        mag_ext;
    logic [CLIP_SEG_BITS-1:0] seg;
    logic [CLIP_VAL_BITS-1:0] pt_lo;
    logic [CLIP_VAL_BITS-1:0] pt_hi;
    logic [CLIP_VAL_BITS-1:0] pt_diff;
    logic [PCM_BITS-1:0]  clip_mag;
    logic                 accept;
    logic                 out_free;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign pcm_out   = pcm_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign wet_eff = (wet_reg > WET_ONE) ? WET_ONE : wet_reg;
    assign dry     = WET_ONE - wet_eff;

    aprsc_ram #(
        .WIDTH (W),
        .DEPTH (LONG_DELAY_SAMPLES)
    ) u_long_ram (
        .clk   (clk),
        .we    (long_we),
        .waddr (long_pos_reg),
        .wdata (ram_wdata),
        .re    (long_re),
        .raddr (long_raddr),
        .rdata (long_rdata)
    );

    aprsc_ram #(
        .WIDTH (W),
        .DEPTH (SHORT_DELAY_SAMPLES)
    ) u_short_ram (
        .clk   (clk),
        .we    (short_we),
        .waddr (short_pos_reg),
        .wdata (ram_wdata),
        .re    (short_re),
        .raddr (short_pos_reg),
        .rdata (short_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        long_pos_next     = long_pos_reg;
        short_pos_next    = short_pos_reg;
        long_filled_next  = long_filled_reg;
        short_filled_next = short_filled_reg;
        out_valid_next    = out_valid_reg;
        s_next            = s_reg;
        x_next            = x_reg;
        d_next            = d_reg;
        w_next            = w_reg;
        prod_next         = prod_reg;
        acc_next          = acc_reg;
        mix_next          = mix_reg;
        clip_lo_next      = clip_lo_reg;
        clip_neg_next     = clip_neg_reg;
        clip_last_next    = clip_last_reg;
        pcm_next          = pcm_reg;

        long_we    = 1'b0;
        long_re    = 1'b0;
        long_raddr = long_pos_reg;
        short_we   = 1'b0;
        short_re   = 1'b0;

        mul_a = '0;
        mul_b = '0;

        d_sel = (state_reg == ST_L_GD) ? (long_filled_reg ? $signed(long_rdata) : '0)
                                       : (short_filled_reg ? $signed(short_rdata) : '0);
        w_val = sat_word(VW'(x_reg) + rnd_q15(VW'(prod_reg)));
        y_val = sat_word(VW'(d_reg) - rnd_q15(VW'(prod_reg)));
        ram_wdata = w_val;

        mag     = mix_reg[W-1] ? W'(-mix_reg) : W'(mix_reg);
        mag_ext = VW'(mag);
        seg     = mag_ext[CLIP_STEP_BITS +: CLIP_SEG_BITS];
        pt_lo   = clip_point({1'b0, seg});
        pt_hi   = clip_point({1'b0, seg} + 5'd1);
        pt_diff = pt_hi - pt_lo;

        clip_mag = clip_last_reg ? PCM_BITS'(clip_point(5'(CLIP_SEGMENTS)))
                 : PCM_BITS'(clip_lo_reg)
                   + PCM_BITS'(prod_reg[CLIP_STEP_BITS +: CLIP_VAL_BITS]);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    s_next  = sample_in;
                    x_next  = MA'(sample_in);
                    long_re = 1'b1;
                    if (new_sound)
                    begin
                        // restart both lines: positions to zero, contents read as empty
                        long_pos_next     = '0;
                        short_pos_next    = '0;
                        long_filled_next  = 1'b0;
                        short_filled_next = 1'b0;
                        long_raddr        = '0;
                    end
                    state_next = ST_L_GD;
                end
            end
            ST_L_GD, ST_S_GD:
            begin
                d_next = d_sel;
                mul_a  = MA'(d_sel);
                mul_b  = MB'(gain_reg);
                prod_next  = mul_a * mul_b;
                state_next = (state_reg == ST_L_GD) ? ST_L_WR : ST_S_WR;
            end
            ST_L_WR:
            begin
                w_next  = w_val;
                long_we = 1'b1;
                if (long_pos_reg == LONG_LAST)
                begin
                    long_pos_next    = '0;
                    long_filled_next = 1'b1;
                end
                else
                begin
                    long_pos_next = long_pos_reg + 1'b1;
                end
                state_next = ST_L_GW;
            end
            ST_S_WR:
            begin
                w_next   = w_val;
                short_we = 1'b1;
                if (short_pos_reg == SHORT_LAST)
                begin
                    short_pos_next    = '0;
                    short_filled_next = 1'b1;
                end
                else
                begin
                    short_pos_next = short_pos_reg + 1'b1;
                end
                state_next = ST_S_GW;
            end
            ST_L_GW, ST_S_GW:
            begin
                mul_a = MA'(w_reg);
                mul_b = MB'(gain_reg);
                prod_next  = mul_a * mul_b;
                state_next = (state_reg == ST_L_GW) ? ST_L_OUT : ST_S_OUT;
            end
            ST_L_OUT:
            begin
                x_next     = MA'(y_val);
                short_re   = 1'b1;
                state_next = ST_S_GD;
            end
            ST_S_OUT:
            begin
                // reverb output into x, dry product starts alongside
                x_next     = MA'(y_val);
                mul_a      = MA'(s_reg);
                mul_b      = MB'(dry);
                prod_next  = mul_a * mul_b;
                state_next = ST_M_WET;
            end
            ST_M_WET:
            begin
                acc_next   = prod_reg;
                mul_a      = x_reg;
                mul_b      = MB'(wet_eff);
                prod_next  = mul_a * mul_b;
                state_next = ST_M_SUM;
            end
            ST_M_SUM:
            begin
                mix_next   = sat_word(rnd_q15(VW'(acc_reg) + VW'(prod_reg)));
                state_next = ST_C_MUL;
            end
            ST_C_MUL:
            begin
                clip_neg_next  = mix_reg[W-1];
                clip_last_next = (mag_ext >= CLIP_LIMIT);
                clip_lo_next   = pt_lo;
                mul_a          = MA'($signed({1'b0, pt_diff}));
                mul_b          = MB'(mag_ext[CLIP_STEP_BITS-1:0]);
                prod_next      = mul_a * mul_b;
                state_next     = ST_C_FIN;
            end
            ST_C_FIN:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    pcm_next       = clip_neg_reg ? $signed(-clip_mag) : $signed(clip_mag);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            long_pos_reg     <= '0;
            short_pos_reg    <= '0;
            long_filled_reg  <= 1'b0;
            short_filled_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            long_pos_reg     <= long_pos_next;
            short_pos_reg    <= short_pos_next;
            long_filled_reg  <= long_filled_next;
            short_filled_reg <= short_filled_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wet_reg  <= WET_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WET_MIX:      wet_reg  <= cfg_data[WET_BITS-1:0];
                CFG_ALLPASS_GAIN: gain_reg <= cfg_data[GAIN_BITS-1:0];
                default:          wet_reg  <= wet_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        x_reg         <= x_next;
        d_reg         <= d_next;
        w_reg         <= w_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        mix_reg       <= mix_next;
        clip_lo_reg   <= clip_lo_next;
        clip_neg_reg  <= clip_neg_next;
        clip_last_reg <= clip_last_next;
        pcm_reg       <= pcm_next;
    end

endmodule
